/* hw/rtl/mbd_pkg.sv */
// Shared types, constants and channel arithmetic for the mipmap box downsampler.
// Used by mbd_front, mbd_queue, mbd_back and the top level; no dependencies.
package mbd_pkg;

  // Source geometry
  localparam int MaxWidth   = 4096;
  localparam int StoreDepth = MaxWidth / 2;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int DimW       = 13;

  // Pixel and pair-sum formats: four 8-bit channels, four 9-bit channel sums
  localparam int PixW  = 32;
  localparam int SumW  = 36;

  // Queue between front and back
  localparam int QueueDepth = 2;

  // Configuration registers; indexes beyond the list are ignored
  localparam int CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1
  } cfg_reg_e;

  localparam logic [DimW-1:0] SrcWidthReset  = DimW'(2);
  localparam logic [DimW-1:0] SrcHeightReset = DimW'(2);

  // Work for the back end, decided by the front
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,  // keep pixel as the pair partner
    OP_PAIR  = 2'd1,  // average with the held pixel, emit
    OP_STORE = 2'd2,  // pair sum of an even row into the line store
    OP_QUAD  = 2'd3   // pair sum plus stored sum, emit 2x2 average
  } op_kind_e;

  typedef struct packed {
    op_kind_e             kind;
    logic [PixW-1:0]      pixel;
    logic [AddrW-1:0]     idx;
    logic                 done;
  } op_t;

  // Per-channel sums of two pixels, channel k in bits 9k+8..9k
  function automatic logic [SumW-1:0] pair_sums(input logic [PixW-1:0] a,
                                                input logic [PixW-1:0] b);
    logic [SumW-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[9*k +: 9] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
    end
    return r;
  endfunction

  // Floor average of a pair from its sums
  function automatic logic [PixW-1:0] avg_pair(input logic [SumW-1:0] s);
    logic [PixW-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = s[9*k+1 +: 8];
    end
    return r;
  endfunction

  // Floor average of a 2x2 block from two rows of pair sums
  function automatic logic [PixW-1:0] avg_quad(input logic [SumW-1:0] s1,
                                               input logic [SumW-1:0] s2);
    logic [PixW-1:0] r;
    logic [9:0]      t;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      t = {1'b0, s1[9*k +: 9]} + {1'b0, s2[9*k +: 9]};
      r[8*k +: 8] = t[9:2];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mipmap_box_downsample_core.sv */
// Top level of the mipmap box downsampler: front, work queue and back end.
// Depends on mbd_pkg, mbd_front, mbd_queue and mbd_back.

// Takes one ARGB8888 mip level in raster order and emits the next smaller level,
// accepting one pixel per clock sustained while the output is not stalled. A
// pixel is classified by the front in the cycle it is accepted and queued; the
// back end then takes one queued item per clock while the output is not stalled,
// doing at most one line-store access (a write of even-row pair sums or a
// read for the odd row); a result then waits in the middle and output registers.
// Output and middle-stage registers let the input keep flowing while a result
// waits to be taken. The line store holds 2048 entries and needs no clearing
// pass: every entry is written in an even row before the odd row below reads it.
// Writing either size register restarts the level; write only while the block
// is idle. level_done_o marks the last pixel of each level.
module mipmap_box_downsample_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mbd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mbd_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [mbd_pkg::PixW-1:0]     pixel_i,
  output logic                         mip_valid_o,
  input  logic                         mip_ready_i,
  output logic [mbd_pkg::PixW-1:0]     mip_pixel_o,
  output logic                         level_done_o
);

  logic         push, q_full, pop, q_valid;
  mbd_pkg::op_t push_op, head_op;

  // Accept and classify
  mbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  // Decouple front and back
  mbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  // Execute and deliver
  mbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .op_i         (head_op),
    .pop_o        (pop),
    .mip_valid_o  (mip_valid_o),
    .mip_ready_i  (mip_ready_i),
    .mip_pixel_o  (mip_pixel_o),
    .level_done_o (level_done_o)
  );

endmodule

/* hw/rtl/mbd_front.sv */
// Front end: configuration registers, raster counters and pixel classification.
// Depends on mbd_pkg; feeds classified work into mbd_queue.
module mbd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mbd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mbd_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [mbd_pkg::PixW-1:0]     pixel_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mbd_pkg::op_t                 op_o
);

  logic [mbd_pkg::DimW-1:0] src_w_q, src_w_d;
  logic [mbd_pkg::DimW-1:0] src_h_q, src_h_d;
  logic [mbd_pkg::ColW-1:0] col_q, col_d;
  logic [mbd_pkg::DimW-1:0] row_q, row_d;

  logic [mbd_pkg::DimW-1:0] eff_w, eff_h, last_col, last_row, col_ext;
  logic                     col_last, row_last, col_in, row_in;
  logic                     mode_vert, mode_horiz, op_valid, accept, restart;

  // Clamp the geometry: zero reads as one, width saturates at MaxWidth (4096)
  always_comb begin
    if (src_w_q == '0) begin
      eff_w = mbd_pkg::DimW'(1);
    end else if (src_w_q > mbd_pkg::DimW'(mbd_pkg::MaxWidth)) begin
      eff_w = mbd_pkg::DimW'(mbd_pkg::MaxWidth);
    end else begin
      eff_w = src_w_q;
    end
    eff_h = (src_h_q == '0) ? mbd_pkg::DimW'(1) : src_h_q;
  end

  // Position within the level; a trailing odd row or column is out of range
  assign col_ext  = mbd_pkg::DimW'(col_q);
  assign last_col = {eff_w[mbd_pkg::DimW-1:1], 1'b0} - mbd_pkg::DimW'(1);
  assign last_row = {eff_h[mbd_pkg::DimW-1:1], 1'b0} - mbd_pkg::DimW'(1);
  assign col_last = (col_ext == eff_w - mbd_pkg::DimW'(1));
  assign row_last = (row_q == eff_h - mbd_pkg::DimW'(1));
  assign col_in   = !(eff_w[0] && col_last);
  assign row_in   = !(eff_h[0] && row_last);

  assign mode_vert  = (eff_w == mbd_pkg::DimW'(1));
  assign mode_horiz = !mode_vert && (eff_h == mbd_pkg::DimW'(1));

  // Classify the incoming pixel
  always_comb begin
    op_o.pixel = pixel_i;
    op_o.idx   = col_q[mbd_pkg::ColW-1:1];
    if (mode_vert) begin
      op_valid  = (eff_h != mbd_pkg::DimW'(1)) && row_in;
      op_o.kind = row_q[0] ? mbd_pkg::OP_PAIR : mbd_pkg::OP_HOLD;
      op_o.done = (row_q == last_row);
    end else if (mode_horiz) begin
      op_valid  = col_in;
      op_o.kind = col_q[0] ? mbd_pkg::OP_PAIR : mbd_pkg::OP_HOLD;
      op_o.done = (col_ext == last_col);
    end else begin
      op_valid = row_in && col_in;
      if (!col_q[0]) begin
        op_o.kind = mbd_pkg::OP_HOLD;
      end else if (row_q[0]) begin
        op_o.kind = mbd_pkg::OP_QUAD;
      end else begin
        op_o.kind = mbd_pkg::OP_STORE;
      end
      op_o.done = (row_q == last_row) && (col_ext == last_col);
    end
  end

  assign pixel_ready_o = !q_full_i;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign push_o        = accept && op_valid;

  // Register writes; a write to a listed register restarts the level
  always_comb begin
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (mbd_pkg::cfg_reg_e'(cfg_addr_i))
        mbd_pkg::CFG_SRC_WIDTH: begin
          src_w_d = cfg_wdata_i;
          restart = 1'b1;
        end
        mbd_pkg::CFG_SRC_HEIGHT: begin
          src_h_d = cfg_wdata_i;
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Advance the raster position, wrapping at the end of the level
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + mbd_pkg::DimW'(1);
      end else begin
        col_d = col_q + mbd_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= mbd_pkg::SrcWidthReset;
      src_h_q <= mbd_pkg::SrcHeightReset;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      src_w_q <= src_w_d;
      src_h_q <= src_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_col_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < eff_w)
    else $error("column counter beyond source width");

  a_row_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < eff_h)
    else $error("row counter beyond source height");
`endif

endmodule

/* hw/rtl/mbd_queue.sv */
// Short work queue that decouples the classifying front from the executing back.
// Depends on mbd_pkg for the entry type and depth.
module mbd_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mbd_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mbd_pkg::op_t op_o
);

  localparam int PtrW = (mbd_pkg::QueueDepth > 1) ? $clog2(mbd_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(mbd_pkg::QueueDepth + 1);

  mbd_pkg::op_t    entry_q [mbd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(mbd_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mbd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mbd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full work queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty work queue");
`endif

endmodule

/* hw/rtl/mbd_back.sv */
// Back end: pair partner, line store of even-row pair sums, averaging and output.
// Depends on mbd_pkg; drains work from mbd_queue.
module mbd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  mbd_pkg::op_t             op_i,
  output logic                     pop_o,
  output logic                     mip_valid_o,
  input  logic                     mip_ready_i,
  output logic [mbd_pkg::PixW-1:0] mip_pixel_o,
  output logic                     level_done_o
);

  // Line store of even-row pair sums
  logic [mbd_pkg::SumW-1:0] store_mem [mbd_pkg::StoreDepth];
  logic [mbd_pkg::SumW-1:0] rd_data_q;

  logic [mbd_pkg::PixW-1:0] held_q;
  logic [mbd_pkg::SumW-1:0] sums;

  // Middle stage: one emitting item, a quad item waiting on its store read
  logic                     s1_valid_q;
  mbd_pkg::op_kind_e        s1_kind_q;
  logic [mbd_pkg::SumW-1:0] s1_sum_q;
  logic                     s1_done_q;

  logic                     out_valid_q;
  logic [mbd_pkg::PixW-1:0] out_pixel_q, out_pixel_d;
  logic                     out_done_q;

  logic is_emit, out_can, s1_free, mem_we, mem_re, hold_we;

  assign sums    = mbd_pkg::pair_sums(held_q, op_i.pixel);
  assign is_emit = op_i.kind inside {mbd_pkg::OP_PAIR, mbd_pkg::OP_QUAD};
  assign out_can = !out_valid_q || mip_ready_i;
  assign s1_free = !s1_valid_q || out_can;
  assign pop_o   = q_valid_i && (!is_emit || s1_free);
  assign mem_we  = pop_o && (op_i.kind == mbd_pkg::OP_STORE);
  assign mem_re  = pop_o && (op_i.kind == mbd_pkg::OP_QUAD);
  assign hold_we = pop_o && (op_i.kind == mbd_pkg::OP_HOLD);

  // Write even-row sums, read them back for the odd row below
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[op_i.idx] <= sums;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[op_i.idx];
    end
  end

  // Pair partner and middle-stage payload
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      held_q <= op_i.pixel;
    end
    if (s1_free && pop_o && is_emit) begin
      s1_kind_q <= op_i.kind;
      s1_sum_q  <= sums;
      s1_done_q <= op_i.done;
    end
    if (out_can && s1_valid_q) begin
      out_pixel_q <= out_pixel_d;
      out_done_q  <= s1_done_q;
    end
  end

  // Finish the average
  always_comb begin
    case (s1_kind_q)
      mbd_pkg::OP_QUAD: out_pixel_d = mbd_pkg::avg_quad(rd_data_q, s1_sum_q);
      default:          out_pixel_d = mbd_pkg::avg_pair(s1_sum_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pop_o && is_emit;
      end
      if (out_can) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign mip_valid_o  = out_valid_q;
  assign mip_pixel_o  = out_pixel_q;
  assign level_done_o = out_done_q;

`ifndef SYNTHESIS
  a_s1_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_can) |=> (s1_valid_q && $stable(s1_sum_q) &&
      (s1_kind_q != mbd_pkg::OP_QUAD || $stable(rd_data_q))))
    else $error("middle stage lost its item under an output stall");
`endif

endmodule
